/* hdl/mslt_pkg.sv */
package mslt_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SHOW   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_ENTRY     = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_BADINDEX  = 3'd6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] code;
    logic               stack_index;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value;
    logic               stack_used;
    logic [1:0]         position;
    logic               last;
  } out_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic valid;
    out_t res;
  } emit_t;

endpackage

/* hdl/mslt_ram.sv */
module mslt_ram import mslt_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic               re_i,
  input  logic [AW-1:0]      addr_i,
  input  logic signed [31:0] wdata_i,
  output logic signed [31:0] rdata_o
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

/* hdl/mslt_ctrl.sv */
module mslt_ctrl import mslt_pkg::*; #(
  parameter int STACK_DEPTH = 4,
  parameter int NUM_STACKS  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  in_t   in_data_i,
  output logic  ready_o,
  input  logic  slot_free_i,
  output emit_t emit_o
);

  localparam int SIW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int FW    = $clog2(STACK_DEPTH + 1);
  localparam int PW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int WORDS = NUM_STACKS * STACK_DEPTH;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MIN     = 4'd1;
  localparam logic [3:0] S_PUSH    = 4'd2;
  localparam logic [3:0] S_RM_RD   = 4'd3;
  localparam logic [3:0] S_RM_CMP  = 4'd4;
  localparam logic [3:0] S_NF      = 4'd5;
  localparam logic [3:0] S_SH_RD   = 4'd6;
  localparam logic [3:0] S_SH_EMIT = 4'd7;
  localparam logic [3:0] S_BAD     = 4'd8;

  localparam logic [SIW-1:0] LAST_STACK = SIW'(NUM_STACKS - 1);
  localparam logic [FW-1:0]  FULL_LVL   = FW'(STACK_DEPTH);

  logic [3:0]     state_q, state_d;
  in_t            item_q, item_d;
  logic [SIW-1:0] idx_q, idx_d;
  logic [SIW-1:0] best_q, best_d;
  logic [FW-1:0]  best_fill_q, best_fill_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [FW-1:0]  fill_q [NUM_STACKS];

  logic [FW-1:0]      fill_rd;
  logic               fill_we;
  logic [FW-1:0]      fill_wval;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_addr;
  logic signed [31:0] ram_rdata;
  logic [FW-1:0]      top_slot;
  logic               upd_best;
  logic               code_match;

  assign fill_rd    = fill_q[idx_q];
  assign top_slot   = FW'(fill_rd - 1'b1);
  // separate compares: fill level against the current minimum, and code match
  assign upd_best   = (idx_q == '0) || (fill_rd < best_fill_q);
  assign code_match = (ram_rdata == item_q.code);
  assign ready_o    = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    best_d      = best_q;
    best_fill_d = best_fill_q;
    pos_d       = pos_q;
    fill_we     = 1'b0;
    fill_wval   = fill_rd;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = AW'(32'(idx_q) * STACK_DEPTH + 32'(pos_q));
    emit_o      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          idx_d  = '0;
          pos_d  = '0;
          case (in_data_i.cmd)
            CMD_INSERT: state_d = S_MIN;
            CMD_REMOVE: state_d = S_RM_RD;
            CMD_SHOW: begin
              if (32'(in_data_i.stack_index) >= NUM_STACKS) begin
                state_d = S_BAD;
              end else begin
                idx_d   = SIW'(in_data_i.stack_index);
                state_d = S_SH_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_MIN: begin
        if (upd_best) begin
          best_d      = idx_q;
          best_fill_d = fill_rd;
        end
        if (idx_q == LAST_STACK) begin
          idx_d   = upd_best ? idx_q : best_q;
          state_d = S_PUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_PUSH: begin
        if (slot_free_i) begin
          emit_o.valid          = 1'b1;
          emit_o.res.value      = item_q.code;
          emit_o.res.stack_used = 1'(idx_q);
          emit_o.res.last       = 1'b1;
          if (best_fill_q == FULL_LVL) begin
            emit_o.res.status = ST_FULL;
          end else begin
            emit_o.res.status   = ST_PUSHED;
            emit_o.res.position = 2'(best_fill_q);
            ram_we    = 1'b1;
            ram_addr  = AW'(32'(idx_q) * STACK_DEPTH + 32'(best_fill_q));
            fill_we   = 1'b1;
            fill_wval = FW'(fill_rd + 1'b1);
          end
          state_d = S_IDLE;
        end
      end

      S_RM_RD: begin
        if (fill_rd != '0) begin
          ram_re   = 1'b1;
          ram_addr = AW'(32'(idx_q) * STACK_DEPTH + 32'(top_slot));
          state_d  = S_RM_CMP;
        end else if (idx_q == LAST_STACK) begin
          state_d = S_NF;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_RM_CMP: begin
        if (code_match) begin
          if (slot_free_i) begin
            emit_o.valid          = 1'b1;
            emit_o.res.status     = ST_REMOVED;
            emit_o.res.value      = ram_rdata;
            emit_o.res.stack_used = 1'(idx_q);
            emit_o.res.position   = 2'(top_slot);
            emit_o.res.last       = 1'b1;
            fill_we   = 1'b1;
            fill_wval = top_slot;
            state_d   = S_IDLE;
          end
        end else if (idx_q == LAST_STACK) begin
          state_d = S_NF;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RM_RD;
        end
      end

      S_NF: begin
        if (slot_free_i) begin
          emit_o.valid      = 1'b1;
          emit_o.res.status = ST_NOTFOUND;
          emit_o.res.value  = item_q.code;
          emit_o.res.last   = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SH_RD: begin
        if (fill_rd == '0) begin
          if (slot_free_i) begin
            emit_o.valid          = 1'b1;
            emit_o.res.status     = ST_EMPTY;
            emit_o.res.stack_used = 1'(idx_q);
            emit_o.res.last       = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_SH_EMIT;
        end
      end

      S_SH_EMIT: begin
        if (slot_free_i) begin
          emit_o.valid          = 1'b1;
          emit_o.res.status     = ST_ENTRY;
          emit_o.res.value      = ram_rdata;
          emit_o.res.stack_used = 1'(idx_q);
          emit_o.res.position   = 2'(pos_q);
          emit_o.res.last       = (FW'(pos_q) == top_slot);
          if (FW'(pos_q) == top_slot) begin
            state_d = S_IDLE;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = S_SH_RD;
          end
        end
      end

      S_BAD: begin
        if (slot_free_i) begin
          emit_o.valid          = 1'b1;
          emit_o.res.status     = ST_BADINDEX;
          emit_o.res.stack_used = item_q.stack_index;
          emit_o.res.last       = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // stack index is reset so the fill-level lookup is defined while idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (fill_we) begin
        fill_q[idx_q] <= fill_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    best_q      <= best_d;
    best_fill_q <= best_fill_d;
    pos_q       <= pos_d;
  end

  mslt_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (item_q.code),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_rd <= FULL_LVL) else $error("fill level above depth");
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> slot_free_i) else $error("result emitted into busy slot");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !emit_o.valid && !ram_re && !ram_we)
    else $error("activity while idle");
  a_write_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_PUSH) && fill_we) else $error("stray stack write");
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && emit_o.res.last) |=> (state_q == S_IDLE))
    else $error("sequencer busy after last result");
`endif

endmodule

/* hdl/multi_stack_least_loaded_top.sv */
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | in_data_i  (in_t: cmd, code, stack_index)
// out     | output    | out_valid_o / out_stall_i | out_data_o (out_t: status, value,
//         |           |                        |   stack_used, position, last)
//
// One transaction at a time is worked by a sequencer around separate fill-level and code
// comparators and a single-port stack RAM. Steps per transaction, after the accept cycle:
// insert does one fill compare per stack, then the push; remove does a RAM read and
// top compare per non-empty stack; show does a RAM read and an emit per entry.
// Reset clears the fill counts at once; the RAM is not cleared and needs no pass.
// A stall on the output holds the sequencer at its next result; a new input
// transaction is taken while the last result still sits in the output register.
module multi_stack_least_loaded_top import mslt_pkg::*; #(
  parameter int STACK_DEPTH = 4,
  parameter int NUM_STACKS  = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic  ready;
  logic  slot_free;
  emit_t emit;
  logic  out_valid_q, out_valid_d;
  out_t  out_data_q;

  // output register is free when empty or being drained this cycle
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !ready;

  mslt_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_STACKS  (NUM_STACKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .ready_o     (ready),
    .slot_free_i (slot_free),
    .emit_o      (emit)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_data_q <= emit.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
